### src/exponential_window_fir_unit_assert.svh
// Assertion macros for the checker file.
`ifndef EXPONENTIAL_WINDOW_FIR_UNIT_ASSERT_SVH
`define EXPONENTIAL_WINDOW_FIR_UNIT_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define EWF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define EWF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ewf_pkg.sv
package ewf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int TAP_W     = 17;
	localparam int DECAY_W   = 16;
	localparam int GAIN_W    = 17;
	localparam int LENCFG_W  = 6;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	localparam int ONE_Q16   = 65536;
	localparam int DECAY_RST = 60000;
	localparam int GAIN_RST  = 4096;
	localparam int LEN_RST   = 32;

	// The accumulator is split here for the two partial products with the gain.
	localparam int LO_W  = 24;
	localparam int SHIFT = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_DECAY   = 2'd0,
		REG_NORM_GAIN   = 2'd1,
		REG_TAPS_IN_USE = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_OUT
	} step_t;

	// A step repeats itself while its hold condition is true.
	typedef enum logic [1:0] {
		HOLD_NEVER,
		HOLD_NO_INPUT,
		HOLD_MORE_TAPS,
		HOLD_OUT_BUSY
	} hold_t;

	typedef struct packed {
		logic  take_in;
		logic  rd_issue;
		logic  mul_lo;
		logic  mul_hi;
		logic  out_load;
		hold_t hold;
		step_t next;
	} ctl_t;

	function automatic ctl_t ucode(step_t s);
		ctl_t w;
		w = '0;
		w.hold = HOLD_NEVER;
		w.next = ST_IDLE;
		case (s)
			ST_IDLE: begin
				w.take_in = 1'b1;
				w.hold    = HOLD_NO_INPUT;
				w.next    = ST_READ;
			end
			ST_READ: begin
				w.rd_issue = 1'b1;
				w.hold     = HOLD_MORE_TAPS;
				w.next     = ST_DRAIN;
			end
			ST_DRAIN: begin
				w.next = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				w.mul_lo = 1'b1;
				w.next   = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				w.mul_hi = 1'b1;
				w.next   = ST_OUT;
			end
			ST_OUT: begin
				w.out_load = 1'b1;
				w.hold     = HOLD_OUT_BUSY;
				w.next     = ST_IDLE;
			end
			default: begin
				w.next = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

### src/ewf_if.sv
interface ewf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ewf_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface ewf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ewf_pkg::SAMPLE_W-1:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

### src/exponential_window_fir_unit.sv
// Channel   Direction  Payload            Width
// samples   sink       sample             16, signed
// results   source     filtered           16, signed
// cfg       write      cfg_idx, cfg_data  2, 17
//
// An item passes from acceptance to a loaded result through one accept step, one
// history read per tap through the single shared multiply-accumulate, one drain
// step, two steps of partial products with the gain and one output load.
// A result waiting in the output register stalls the load step only; reset clears
// the history through per-entry valid bits, so no clearing pass is needed.
module exponential_window_fir_unit #(
	parameter int MAX_TAPS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ewf_in_if.sink                          samples,
	ewf_out_if.source                       results,
	input  logic                            cfg_we,
	input  logic [ewf_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ewf_pkg::CFG_W-1:0]       cfg_data
);

	localparam int SLOT_W  = $clog2(MAX_TAPS);
	localparam int LEN_W   = $clog2(MAX_TAPS + 1);
	localparam int CMP_W   = (LEN_W > ewf_pkg::LENCFG_W) ? LEN_W : ewf_pkg::LENCFG_W;
	localparam int LEN_RST = (ewf_pkg::LEN_RST > MAX_TAPS) ? MAX_TAPS : ewf_pkg::LEN_RST;
	localparam int MACP_W  = ewf_pkg::SAMPLE_W + ewf_pkg::TAP_W + 1;
	localparam int TPROD_W = ewf_pkg::TAP_W + ewf_pkg::DECAY_W;
	localparam int ACC_W   = 32 + $clog2(MAX_TAPS);
	localparam int HI_W    = ACC_W - ewf_pkg::LO_W;
	localparam int PLO_W   = ewf_pkg::LO_W + ewf_pkg::GAIN_W;
	localparam int PHI_W   = HI_W + ewf_pkg::GAIN_W + 1;
	localparam int PROD_W  = ACC_W + ewf_pkg::GAIN_W + 1;
	localparam int RES_W   = PROD_W - ewf_pkg::SHIFT;
	localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (ewf_pkg::SHIFT - 1);
	localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
	localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-32768);

	logic [ewf_pkg::DECAY_W-1:0] decay_q;
	logic [ewf_pkg::GAIN_W-1:0]  gain_q;
	logic [LEN_W-1:0]            len_q;
	logic [CMP_W-1:0]            len_req;
	logic [LEN_W-1:0]            len_wr;
	logic                        len_clr;

	ewf_pkg::step_t step_q;
	ewf_pkg::step_t step_d;
	ewf_pkg::ctl_t  ctl;
	logic           hold;
	logic           in_acc;
	logic           out_busy;
	logic           out_fire;

	logic signed [ewf_pkg::SAMPLE_W-1:0] hist_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]                 hist_vld_q;
	logic [SLOT_W-1:0]                   slot_q;
	logic [LEN_W-1:0]                    slot_inc;
	logic [SLOT_W-1:0]                   slot_next;

	logic [SLOT_W-1:0]                   rd_idx_q;
	logic [LEN_W-1:0]                    cnt_q;
	logic signed [ewf_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic                                rd_vld_s1;
	logic                                mac_en_s1;
	logic signed [ewf_pkg::SAMPLE_W-1:0] rd_sample;
	logic signed [MACP_W-1:0]            mac_prod;
	logic [ewf_pkg::TAP_W-1:0]           tap_q;
	logic [TPROD_W-1:0]                  tap_prod;
	logic signed [ACC_W-1:0]             acc_q;
	logic signed [HI_W-1:0]              acc_hi;
	logic [PLO_W-1:0]                    plo_q;
	logic signed [PHI_W-1:0]             phi_q;
	logic [PROD_W-1:0]                   sum_w;
	logic signed [RES_W-1:0]             res;
	logic [ewf_pkg::SAMPLE_W-1:0]        sat;

	logic                                out_valid_q;
	logic [ewf_pkg::SAMPLE_W-1:0]        out_data_q;

	// Configuration registers. A length of zero is held as one, a length above
	// the history depth as the depth.
	always_comb begin
		len_req = CMP_W'(cfg_data[ewf_pkg::LENCFG_W-1:0]);
		if (len_req == '0) begin
			len_req = CMP_W'(1);
		end else if (len_req > CMP_W'(MAX_TAPS)) begin
			len_req = CMP_W'(MAX_TAPS);
		end
		len_wr  = LEN_W'(len_req);
		len_clr = cfg_we && (cfg_idx == ewf_pkg::REG_TAPS_IN_USE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= ewf_pkg::DECAY_W'(ewf_pkg::DECAY_RST);
			gain_q  <= ewf_pkg::GAIN_W'(ewf_pkg::GAIN_RST);
			len_q   <= LEN_W'(LEN_RST);
		end else if (cfg_we) begin
			case (ewf_pkg::cfg_reg_t'(cfg_idx))
				ewf_pkg::REG_TAP_DECAY:   decay_q <= cfg_data[ewf_pkg::DECAY_W-1:0];
				ewf_pkg::REG_NORM_GAIN:   gain_q  <= cfg_data[ewf_pkg::GAIN_W-1:0];
				ewf_pkg::REG_TAPS_IN_USE: len_q   <= len_wr;
				default: ;
			endcase
		end
	end

	// Sequencer: the step register fetches its control word from the program.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ewf_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctl      = ewf_pkg::ucode(step_q);
		out_busy = out_valid_q && !results.ready;
		case (ctl.hold)
			ewf_pkg::HOLD_NEVER:     hold = 1'b0;
			ewf_pkg::HOLD_NO_INPUT:  hold = !samples.valid;
			ewf_pkg::HOLD_MORE_TAPS: hold = (cnt_q != LEN_W'(1));
			ewf_pkg::HOLD_OUT_BUSY:  hold = out_busy;
			default:                 hold = 1'b0;
		endcase
		step_d   = hold ? step_q : ctl.next;
		in_acc   = samples.valid && ctl.take_in;
		out_fire = ctl.out_load && !out_busy;
	end

	assign samples.ready = ctl.take_in;

	// History write slot and per-entry valid bits.
	always_comb begin
		slot_inc  = LEN_W'(slot_q) + LEN_W'(1);
		slot_next = (slot_inc >= len_q) ? '0 : SLOT_W'(slot_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			hist_vld_q <= '0;
		end else if (len_clr) begin
			slot_q     <= '0;
			hist_vld_q <= '0;
		end else begin
			if (in_acc) begin
				hist_vld_q[slot_q] <= 1'b1;
			end
			if (out_fire) begin
				slot_q <= slot_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hist_mem[slot_q] <= samples.sample;
		end
		rd_data_s1 <= hist_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_en_s1 <= 1'b0;
		end else begin
			mac_en_s1 <= ctl.rd_issue;
		end
	end

	// Shared multiply-accumulate and the tap recurrence.
	always_comb begin
		rd_sample = rd_vld_s1 ? rd_data_s1 : '0;
		mac_prod  = rd_sample * $signed({1'b0, tap_q});
		tap_prod  = tap_q * decay_q;
		acc_hi    = acc_q[ACC_W-1:ewf_pkg::LO_W];
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= hist_vld_q[rd_idx_q];
		if (in_acc) begin
			rd_idx_q <= slot_q;
			cnt_q    <= len_q;
			acc_q    <= '0;
			tap_q    <= ewf_pkg::TAP_W'(ewf_pkg::ONE_Q16);
		end else if (ctl.rd_issue) begin
			// Walk back from the newest sample, wrapping at the active length.
			rd_idx_q <= (rd_idx_q == '0) ? SLOT_W'(len_q - LEN_W'(1)) : rd_idx_q - SLOT_W'(1);
			cnt_q    <= cnt_q - LEN_W'(1);
		end
		if (mac_en_s1) begin
			acc_q <= acc_q + ACC_W'(mac_prod);
			tap_q <= tap_prod[TPROD_W-1:ewf_pkg::DECAY_W];
		end
		if (ctl.mul_lo) begin
			plo_q <= PLO_W'(acc_q[ewf_pkg::LO_W-1:0]) * PLO_W'(gain_q);
		end
		if (ctl.mul_hi) begin
			phi_q <= acc_hi * $signed({1'b0, gain_q});
		end
	end

	// Recombine the partial products, round half up, shift down and saturate.
	always_comb begin
		sum_w = (PROD_W'(phi_q) << ewf_pkg::LO_W) + PROD_W'(plo_q) + RND;
		res   = $signed(sum_w[PROD_W-1:ewf_pkg::SHIFT]);
		if (res > SAT_HI) begin
			sat = SAT_HI[ewf_pkg::SAMPLE_W-1:0];
		end else if (res < SAT_LO) begin
			sat = SAT_LO[ewf_pkg::SAMPLE_W-1:0];
		end else begin
			sat = res[ewf_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			out_data_q <= sat;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.filtered = out_data_q;

endmodule

### src/ewf_check.sv
`include "exponential_window_fir_unit_assert.svh"

module ewf_check (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [ewf_pkg::SAMPLE_W-1:0]        out_filtered
);

	// A result that is not taken stays put.
	`EWF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_filtered), "result dropped or changed while stalled")

	// After an item is taken the block takes no other while it is busy with it.
	`EWF_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready, "new item taken while one is in work")

	// A new result only appears at the end of a computation, never while idle.
	`EWF_ASSERT(a_result_from_work, $rose(out_valid) |-> !$past(in_ready), "result appeared without an item in work")

	`EWF_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result shown during reset")

endmodule

bind exponential_window_fir_unit ewf_check u_ewf_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_filtered (results.filtered)
);

### bench/tb_exponential_window_fir_unit.sv
module tb_exponential_window_fir_unit;

	localparam int MAX_TAPS = 32;
	localparam int PHASES = 16;
	localparam int ITEMS_PER_PHASE = 110;
	// Index 3 selects no register; writes to it must change nothing.
	localparam logic [ewf_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ewf_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [ewf_pkg::CFG_W-1:0] cfg_data;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;

	ewf_in_if in_ch();
	ewf_out_if out_ch();

	exponential_window_fir_unit #(
		.MAX_TAPS(MAX_TAPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.results(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	class fir_scoreboard;
		logic [ewf_pkg::DECAY_W-1:0] decay;
		logic [ewf_pkg::GAIN_W-1:0] gain;
		int unsigned taps;
		logic signed [ewf_pkg::SAMPLE_W-1:0] history [MAX_TAPS];
		int unsigned wr_slot;
		logic signed [ewf_pkg::SAMPLE_W-1:0] expected_filtered [$];
		int errors;

		function new();
			decay = ewf_pkg::DECAY_W'(ewf_pkg::DECAY_RST);
			gain = ewf_pkg::GAIN_W'(ewf_pkg::GAIN_RST);
			taps = ewf_pkg::LEN_RST;
			errors = 0;
			clear_history();
		endfunction

		function void clear_history();
			foreach (history[i]) begin
				history[i] = '0;
			end
			wr_slot = 0;
		endfunction

		function void set_reg(logic [ewf_pkg::CFG_IDX_W-1:0] idx,
				logic [ewf_pkg::CFG_W-1:0] data);
			int unsigned len;
			case (idx)
				ewf_pkg::REG_TAP_DECAY: begin
					decay = data[ewf_pkg::DECAY_W-1:0];
				end
				ewf_pkg::REG_NORM_GAIN: begin
					gain = data[ewf_pkg::GAIN_W-1:0];
				end
				ewf_pkg::REG_TAPS_IN_USE: begin
					len = 32'(data[ewf_pkg::LENCFG_W-1:0]);
					if (len < 1) begin
						len = 1;
					end
					if (len > MAX_TAPS) begin
						len = MAX_TAPS;
					end
					taps = len;
					clear_history();
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return expected_filtered.size();
		endfunction

		// Stores the sample, then forms the decaying weighted sum newest first
		// and scales it by the gain with round-half-up and saturation.
		function void note_sample(logic signed [ewf_pkg::SAMPLE_W-1:0] s);
			int unsigned slot;
			int unsigned idx;
			logic [ewf_pkg::TAP_W-1:0] tap;
			longint acc;
			longint scaled;
			logic signed [ewf_pkg::SAMPLE_W-1:0] filtered;
			slot = wr_slot % taps;
			history[slot] = s;
			tap = ewf_pkg::TAP_W'(ewf_pkg::ONE_Q16);
			acc = 0;
			for (int unsigned i = 0; i < taps; i++) begin
				idx = (slot + taps - i) % taps;
				acc += longint'(history[idx]) * longint'(tap);
				tap = ewf_pkg::TAP_W'((longint'(tap) * longint'(decay)) >> 16);
			end
			scaled = (acc * longint'(gain) + (longint'(1) << 31)) >>> ewf_pkg::SHIFT;
			if (scaled > 32767) begin
				filtered = 16'sh7FFF;
			end else if (scaled < -32768) begin
				filtered = 16'sh8000;
			end else begin
				filtered = ewf_pkg::SAMPLE_W'(scaled);
			end
			expected_filtered.push_back(filtered);
			wr_slot = (slot + 1 >= taps) ? 0 : slot + 1;
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		task check_result(logic signed [ewf_pkg::SAMPLE_W-1:0] got);
			logic signed [ewf_pkg::SAMPLE_W-1:0] want;
			if (expected_filtered.size() == 0) begin
				report_mismatch($sformatf("filtered %0d with no item pending", got));
			end else begin
				want = expected_filtered.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("filtered %0d, expected %0d", got, want));
				end
			end
		endtask
	endclass

	fir_scoreboard sb;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sb.note_sample(in_ch.sample);
			end
			if (out_ch.valid && out_ch.ready) begin
				sb.check_result(out_ch.filtered);
			end
		end
	end

	// Result side: random stalls, or a forced hold-off while hold_cycles runs down.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 65;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 65;
			end
			default: begin
				send_idle_pct = 10;
				recv_stall_pct = 10;
			end
		endcase
	endtask

	// Called and returns at a falling edge.
	task automatic send_sample(logic signed [ewf_pkg::SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (MAX_TAPS + 8) @(negedge clk);
	endtask

	task automatic write_reg(logic [ewf_pkg::CFG_IDX_W-1:0] idx,
			logic [ewf_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [ewf_pkg::GAIN_W-1:0] normalized_gain(
			logic [ewf_pkg::DECAY_W-1:0] decay, int unsigned len);
		longint sum;
		longint g;
		logic [ewf_pkg::TAP_W-1:0] tap;
		sum = 0;
		tap = ewf_pkg::TAP_W'(ewf_pkg::ONE_Q16);
		for (int unsigned i = 0; i < len; i++) begin
			sum += longint'(tap);
			tap = ewf_pkg::TAP_W'((longint'(tap) * longint'(decay)) >> 16);
		end
		g = ((longint'(1) << 32) + sum / 2) / sum;
		return (g > 131071) ? 17'h1FFFF : ewf_pkg::GAIN_W'(g);
	endfunction

	function automatic logic signed [ewf_pkg::SAMPLE_W-1:0] random_sample();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1: return $signed(16'($urandom_range(32))) - 16'sd16;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [ewf_pkg::DECAY_W-1:0] decay_v;
		logic [ewf_pkg::LENCFG_W-1:0] len_v;
		logic [ewf_pkg::GAIN_W-1:0] gain_v;
		sb = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Settings after reset.
		send_sample(16'sh7FFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_sample(16'sd1);
		wait_drained();

		// One tap at nearly twice unity gain saturates both ways; the decay
		// write carries a stray upper bit that must be dropped.
		write_reg(ewf_pkg::REG_TAP_DECAY, 17'h10000);
		write_reg(ewf_pkg::REG_NORM_GAIN, 17'h1FFFF);
		write_reg(ewf_pkg::REG_TAPS_IN_USE, 17'd1);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd300);
		send_sample(-16'sd300);
		wait_drained();

		// A length of zero is held as one, so the output follows the input.
		write_reg(ewf_pkg::REG_TAP_DECAY, 17'hFFFF);
		write_reg(ewf_pkg::REG_NORM_GAIN, 17'd65536);
		write_reg(ewf_pkg::REG_TAPS_IN_USE, 17'd0);
		send_sample(16'sd12345);
		send_sample(-16'sd7);
		wait_drained();

		// A length beyond the history is held at the full history.
		write_reg(ewf_pkg::REG_NORM_GAIN, 17'd2048);
		write_reg(ewf_pkg::REG_TAPS_IN_USE, 17'h1FFFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sh7FFF);
		wait_drained();

		// A write to the unused index leaves every register and the history alone.
		write_reg(REG_NONE, 17'h1FFFF);
		send_sample(16'sd1000);
		send_sample(-16'sd1000);
		wait_drained();

		write_reg(ewf_pkg::REG_NORM_GAIN, 17'd0);
		send_sample(16'sh7FFF);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			set_idling(idle_mode_t'(p % 4));
			case ($urandom_range(5))
				0: decay_v = '0;
				1: decay_v = 16'hFFFF;
				default: decay_v = 16'($urandom);
			endcase
			write_reg(ewf_pkg::REG_TAP_DECAY, {1'($urandom), decay_v});
			// Some phases keep the history running across the new settings.
			if (p % 3 != 2) begin
				case ($urandom_range(7))
					0: len_v = '0;
					1: len_v = 6'($urandom_range(33, 63));
					2: len_v = 6'd32;
					3: len_v = 6'd1;
					default: len_v = 6'($urandom_range(1, 32));
				endcase
				write_reg(ewf_pkg::REG_TAPS_IN_USE, {11'($urandom), len_v});
			end
			case ($urandom_range(7))
				0: gain_v = '0;
				1: gain_v = 17'h1FFFF;
				2: gain_v = 17'd65536;
				3: gain_v = 17'($urandom);
				default: gain_v = normalized_gain(sb.decay, sb.taps);
			endcase
			write_reg(ewf_pkg::REG_NORM_GAIN, gain_v);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 5 && n == 20) begin
					hold_cycles = 300;
				end
				if (p == 10 && n == 55) begin
					wait_drained();
				end
				send_sample(random_sample());
			end
			wait_drained();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+src
src/ewf_pkg.sv
src/ewf_if.sv
src/exponential_window_fir_unit.sv
src/ewf_check.sv
bench/tb_exponential_window_fir_unit.sv
